/* rtl/core/modular_matrix_power_macros.svh */
// Assertion macros for the modular matrix power block.
// Needs clk and rst_n in the scope of each use.
`ifndef MODULAR_MATRIX_POWER_MACROS_SVH
`define MODULAR_MATRIX_POWER_MACROS_SVH

// Check that holds outside reset.
`define MMP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also covers the reset cycles.
`define MMP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/mmp_pkg.sv */
// Package for the modular matrix power block: types, constants, helpers.
// No dependencies.
package mmp_pkg;

  localparam int VAL_W       = 30;
  localparam int IDX_W       = 6;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;
  localparam int EXP_W       = 32;
  localparam int BIT_W       = 5;

  localparam logic [VAL_W-1:0] MODULUS    = 30'd1000000007;
  // floor(2^60 / MODULUS)
  localparam logic [30:0]      BARRETT_MU = 31'd1152921496;

  typedef struct packed {
    logic             vld;
    logic             last;
    logic [IDX_W-1:0] dest;
  } mac_tag_t;

  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] addr;
    logic [VAL_W-1:0] data;
  } mac_wr_t;

  // One conditional subtract of the modulus.
  function automatic logic [31:0] red1(input logic [31:0] v);
    logic [31:0] m;
    m = {2'b00, MODULUS};
    return (v >= m) ? (v - m) : v;
  endfunction

endpackage

/* rtl/core/mmp_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module mmp_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/mmp_mac.sv */
// Pipelined modular multiply-accumulate: 30x30 product, Barrett reduction,
// running dot-product sum. Depends on mmp_pkg.
module mmp_mac import mmp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [VAL_W-1:0] op_a,
  input  logic [VAL_W-1:0] op_b,
  input  mac_tag_t         tag_i,
  output mac_wr_t          wr_o,
  output logic             busy
);

  mac_tag_t         s1_tag_r, s2_tag_r, s3_tag_r, s4_tag_r, s5_tag_r;
  logic [59:0]      s1_x_r;
  logic [61:0]      s2_q_r;
  logic [31:0]      s2_xlo_r, s3_xlo_r, s3_qp_r, s4_r_r;
  logic [VAL_W-1:0] s5_t_r, acc_r, acc_nxt;
  logic [31:0]      sum, sum_red;
  mac_wr_t          wr_r, wr_nxt;

  assign sum     = {2'b00, acc_r} + {2'b00, s5_t_r};
  assign sum_red = red1(sum);

  always_comb begin
    acc_nxt = acc_r;
    wr_nxt  = '0;
    if (s5_tag_r.vld) begin
      if (s5_tag_r.last) begin
        acc_nxt     = '0;
        wr_nxt.vld  = 1'b1;
        wr_nxt.addr = s5_tag_r.dest;
        wr_nxt.data = sum_red[VAL_W-1:0];
      end else begin
        acc_nxt = sum_red[VAL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tag_r <= '0;
      s2_tag_r <= '0;
      s3_tag_r <= '0;
      s4_tag_r <= '0;
      s5_tag_r <= '0;
      wr_r     <= '0;
      acc_r    <= '0;
    end else begin
      s1_tag_r <= tag_i;
      s2_tag_r <= s1_tag_r;
      s3_tag_r <= s2_tag_r;
      s4_tag_r <= s3_tag_r;
      s5_tag_r <= s4_tag_r;
      wr_r     <= wr_nxt;
      acc_r    <= acc_nxt;
    end
    // payload
    s1_x_r   <= 60'(op_a) * 60'(op_b);
    s2_q_r   <= 62'(s1_x_r[59:29]) * 62'(BARRETT_MU);
    s2_xlo_r <= s1_x_r[31:0];
    s3_qp_r  <= 32'(s2_q_r[61:31]) * 32'(MODULUS);
    s3_xlo_r <= s2_xlo_r;
    // Barrett leaves at most two extra moduli
    s4_r_r   <= red1(s3_xlo_r - s3_qp_r);
    s5_t_r   <= VAL_W'(red1(s4_r_r));
  end

  assign wr_o = wr_r;
  assign busy = s1_tag_r.vld | s2_tag_r.vld | s3_tag_r.vld | s4_tag_r.vld |
                s5_tag_r.vld | wr_r.vld;

endmodule

/* rtl/core/modular_matrix_power.sv */
// Top level of the modular matrix power block: sequencer, matrix RAMs, MAC.
// Depends on mmp_pkg, mmp_ram, mmp_mac and modular_matrix_power_macros.svh.
//
// Usage:
//  - in_*: one matrix element per word (in_tdata[29:0]), row-major, DIM*DIM
//    words per matrix. Elements of 1000000007 or more are reduced once.
//  - out_*: DIM*DIM result words, row-major; out_tdata[29:0] is the value,
//    out_tdata[35:30] its row-major index, out_tlast marks the final one.
//  - cfg_wr_en/cfg_wr_data: exponent, written while the block is idle.
//  - Loading takes one word per cycle. After the last element the block
//    computes base^exponent mod 1000000007 by square-and-multiply over all
//    32 exponent bits, with one pipelined MAC fed from the matrix RAMs.
//    Each matrix product issues DIM^3 MAC operations, drains the MAC and
//    copies the product back into the power RAMs; there are 32 squarings
//    plus one product per set exponent bit, after the power RAMs are set
//    to the identity matrix.
//  - Output reads each word from the RAM before presenting it; a stalled
//    receiver holds the word (RAM address fixed) and the block simply waits.
//  - in_tready is high only while loading; no new matrix is taken until
//    the last result word is accepted.
//  - Reset (rst_n low, synchronous) returns to loading with an empty
//    matrix and exponent zero. RAM contents are not cleared.
`include "modular_matrix_power_macros.svh"

module modular_matrix_power import mmp_pkg::*; #(
  parameter int DIM = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [29:0] element_value
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [29:0] result_value, [35:30] result_index
  output logic                   out_tlast,
  input  logic                   cfg_wr_en,
  input  logic [EXP_W-1:0]       cfg_wr_data
);

  localparam int CELLS = DIM * DIM;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = (DIM > 1) ? $clog2(DIM) : 1;

  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [CW-1:0] LAST_RC   = CW'(DIM - 1);
  localparam logic [AW:0]   CELLS_CNT = (AW + 1)'(CELLS);

  typedef enum logic [2:0] {
    S_LOAD, S_INIT, S_MUL, S_DRAIN, S_COPY, S_OUT
  } state_t;

  state_t           state_r, state_nxt;
  logic [AW-1:0]    ld_r, ld_nxt;
  logic [CW-1:0]    r_r, r_nxt, c_r, c_nxt, k_r, k_nxt;
  logic [BIT_W-1:0] bit_r, bit_nxt;
  logic             sq_r, sq_nxt;
  logic [AW:0]      cp_cnt_r, cp_cnt_nxt;
  logic             cp_v_r, cp_v_nxt;
  logic [AW-1:0]    cp_a_r, cp_a_nxt;
  logic [AW-1:0]    out_idx_r, out_idx_nxt;
  logic             out_v_r, out_v_nxt, fetch_r, fetch_nxt;
  logic [EXP_W-1:0] exp_r;
  mac_tag_t         tag_r, tag_nxt;

  logic             in_acc;
  logic [31:0]      in_red;
  logic [AW-1:0]    a_addr, b_addr, rc_addr;
  logic [VAL_W-1:0] base_rd, pa_rd, pb_rd, sc_rd, b_op, pw_data;
  logic [AW-1:0]    pw_addr, pa_raddr;
  logic             pw_we, mac_busy;
  mac_wr_t          mac_wr;

  assign in_acc  = in_tvalid & in_tready;
  assign in_red  = red1({2'b00, in_tdata[VAL_W-1:0]});
  assign a_addr  = AW'(AW'(r_r) * AW'(DIM) + AW'(k_r));
  assign b_addr  = AW'(AW'(k_r) * AW'(DIM) + AW'(c_r));
  assign rc_addr = AW'(AW'(r_r) * AW'(DIM) + AW'(c_r));

  // power RAM is kept in two identical copies so squaring gets two reads
  assign pw_we    = (state_r == S_INIT) | cp_v_r;
  assign pw_addr  = (state_r == S_INIT) ? rc_addr : cp_a_r;
  assign pw_data  = (state_r == S_INIT) ? ((r_r == c_r) ? VAL_W'(1) : '0) : sc_rd;
  assign pa_raddr = (state_r == S_OUT) ? out_idx_r : a_addr;
  assign b_op     = sq_r ? pb_rd : base_rd;

  mmp_ram #(.WIDTH(VAL_W), .DEPTH(CELLS)) u_base (
    .clk(clk), .we(in_acc), .waddr(ld_r), .wdata(in_red[VAL_W-1:0]),
    .raddr(b_addr), .rdata(base_rd)
  );

  mmp_ram #(.WIDTH(VAL_W), .DEPTH(CELLS)) u_pow_a (
    .clk(clk), .we(pw_we), .waddr(pw_addr), .wdata(pw_data),
    .raddr(pa_raddr), .rdata(pa_rd)
  );

  mmp_ram #(.WIDTH(VAL_W), .DEPTH(CELLS)) u_pow_b (
    .clk(clk), .we(pw_we), .waddr(pw_addr), .wdata(pw_data),
    .raddr(b_addr), .rdata(pb_rd)
  );

  mmp_ram #(.WIDTH(VAL_W), .DEPTH(CELLS)) u_scratch (
    .clk(clk), .we(mac_wr.vld), .waddr(mac_wr.addr[AW-1:0]), .wdata(mac_wr.data),
    .raddr(cp_cnt_r[AW-1:0]), .rdata(sc_rd)
  );

  // tag_r lines up with the registered RAM read data
  mmp_mac u_mac (
    .clk(clk), .rst_n(rst_n), .op_a(pa_rd), .op_b(b_op),
    .tag_i(tag_r), .wr_o(mac_wr), .busy(mac_busy)
  );

  always_comb begin
    state_nxt   = state_r;
    ld_nxt      = ld_r;
    r_nxt       = r_r;
    c_nxt       = c_r;
    k_nxt       = k_r;
    bit_nxt     = bit_r;
    sq_nxt      = sq_r;
    cp_cnt_nxt  = cp_cnt_r;
    cp_v_nxt    = 1'b0;
    cp_a_nxt    = cp_cnt_r[AW-1:0];
    out_idx_nxt = out_idx_r;
    out_v_nxt   = out_v_r;
    fetch_nxt   = fetch_r;
    tag_nxt     = '0;
    case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (ld_r == LAST_CELL) begin
            ld_nxt    = '0;
            r_nxt     = '0;
            c_nxt     = '0;
            state_nxt = S_INIT;
          end else begin
            ld_nxt = ld_r + 1'b1;
          end
        end
      end
      S_INIT: begin
        if (c_r == LAST_RC) begin
          c_nxt = '0;
          if (r_r == LAST_RC) begin
            r_nxt     = '0;
            k_nxt     = '0;
            bit_nxt   = '1;
            sq_nxt    = 1'b1;
            state_nxt = S_MUL;
          end else begin
            r_nxt = r_r + 1'b1;
          end
        end else begin
          c_nxt = c_r + 1'b1;
        end
      end
      S_MUL: begin
        tag_nxt.vld  = 1'b1;
        tag_nxt.last = (k_r == LAST_RC);
        tag_nxt.dest = IDX_W'(rc_addr);
        if (k_r == LAST_RC) begin
          k_nxt = '0;
          if (c_r == LAST_RC) begin
            c_nxt = '0;
            if (r_r == LAST_RC) begin
              r_nxt     = '0;
              state_nxt = S_DRAIN;
            end else begin
              r_nxt = r_r + 1'b1;
            end
          end else begin
            c_nxt = c_r + 1'b1;
          end
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_DRAIN: begin
        if (!tag_r.vld && !mac_busy) begin
          cp_cnt_nxt = '0;
          state_nxt  = S_COPY;
        end
      end
      S_COPY: begin
        if (cp_cnt_r < CELLS_CNT) begin
          cp_v_nxt   = 1'b1;
          cp_cnt_nxt = cp_cnt_r + 1'b1;
        end else if (sq_r && exp_r[bit_r]) begin
          sq_nxt    = 1'b0;
          state_nxt = S_MUL;
        end else if (bit_r == '0) begin
          out_idx_nxt = '0;
          fetch_nxt   = 1'b1;
          out_v_nxt   = 1'b0;
          state_nxt   = S_OUT;
        end else begin
          bit_nxt   = bit_r - 1'b1;
          sq_nxt    = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_OUT: begin
        if (out_v_r) begin
          if (out_tready) begin
            out_v_nxt = 1'b0;
            if (out_idx_r == LAST_CELL) begin
              state_nxt = S_LOAD;
            end else begin
              out_idx_nxt = out_idx_r + 1'b1;
              fetch_nxt   = 1'b1;
            end
          end
        end else if (fetch_r) begin
          fetch_nxt = 1'b0;
          out_v_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_LOAD;
      ld_r      <= '0;
      r_r       <= '0;
      c_r       <= '0;
      k_r       <= '0;
      bit_r     <= '0;
      sq_r      <= 1'b1;
      cp_cnt_r  <= '0;
      cp_v_r    <= 1'b0;
      out_idx_r <= '0;
      out_v_r   <= 1'b0;
      fetch_r   <= 1'b0;
      tag_r     <= '0;
      exp_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      ld_r      <= ld_nxt;
      r_r       <= r_nxt;
      c_r       <= c_nxt;
      k_r       <= k_nxt;
      bit_r     <= bit_nxt;
      sq_r      <= sq_nxt;
      cp_cnt_r  <= cp_cnt_nxt;
      cp_v_r    <= cp_v_nxt;
      out_idx_r <= out_idx_nxt;
      out_v_r   <= out_v_nxt;
      fetch_r   <= fetch_nxt;
      tag_r     <= tag_nxt;
      if (cfg_wr_en) begin
        exp_r <= cfg_wr_data;
      end
    end
    cp_a_r <= cp_a_nxt;
  end

  assign in_tready  = (state_r == S_LOAD);
  assign out_tvalid = out_v_r;
  assign out_tlast  = (out_idx_r == LAST_CELL);
  assign out_tdata  = {{(OUT_TDATA_W - VAL_W - IDX_W){1'b0}}, IDX_W'(out_idx_r), pa_rd};

  `MMP_ASSERT(a_out_only_in_out, out_tvalid |-> (state_r == S_OUT), "result word outside output phase")
  `MMP_ASSERT(a_mac_wr_phase, mac_wr.vld |-> (state_r == S_MUL || state_r == S_DRAIN), "MAC write outside product phase")
  `MMP_ASSERT(a_copy_phase, cp_v_r |-> (state_r == S_COPY), "copy write outside copy phase")
  `MMP_ASSERT(a_load_done, (in_acc && ld_r == LAST_CELL) |=> (state_r == S_INIT), "full matrix did not start compute")
  `MMP_ASSERT_RST(a_reset_idle, !rst_n |=> (state_r == S_LOAD && !out_tvalid), "reset did not return to load")

endmodule
